// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/osfc_pkg.sv =====
// ----------------------------------------------------------------------------
// osfc_pkg
// Types and constants shared by the omni shadow face cull pipeline.
// ----------------------------------------------------------------------------
package osfc_pkg;

    localparam int COORD_BITS     = 32;
    localparam int HALF_BITS      = COORD_BITS - 1;
    localparam int SLOPE_BITS     = 24;
    localparam int AXES           = 3;
    localparam int FACES          = 6;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [FACES-1:0] ALL_FACES = {FACES{1'b1}};

    localparam logic [HALF_BITS-1:0]         NEAR_RESET  = HALF_BITS'(6554);
    localparam logic [HALF_BITS-1:0]         FAR_RESET   = HALF_BITS'(6553600);
    localparam logic [SLOPE_BITS-1:0]        SLOPE_RESET = SLOPE_BITS'(65536);
    localparam logic signed [COORD_BITS-1:0] LIGHT_RESET = '0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEAR_CLIP,
        REG_FAR_CLIP,
        REG_FRUSTUM_SLOPE,
        REG_LIGHT_X,
        REG_LIGHT_Y,
        REG_LIGHT_Z
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic [HALF_BITS-1:0]         half_x;
        logic [HALF_BITS-1:0]         half_y;
        logic [HALF_BITS-1:0]         half_z;
        logic                         eligible;
        logic                         cull_enabled;
    } box_t;

    typedef struct packed {
        logic [FACES-1:0] face_mask;
        logic             visible_this_frame;
    } face_t;

    // Control bits that travel down the pipeline with each transaction.
    typedef struct packed {
        logic valid;
        logic eligible;
        logic cull_enabled;
    } item_flags_t;

    // Width of the wide datapath: products with the slope, plain values
    // scaled up by the fraction bits, and a few sums of those.
    function automatic int wide_bits(input int frac_bits);
        int top;
        top = (frac_bits > SLOPE_BITS) ? frac_bits : SLOPE_BITS;
        return COORD_BITS + 2 + top + 3;
    endfunction

    // The two lateral axes of a face axis, in the order (axis+1), (axis+2).
    function automatic int lateral(input int axis, input int side);
        int s;
        s = axis + side + 1;
        return (s >= AXES) ? s - AXES : s;
    endfunction

endpackage

// ===== rtl/omni_shadow_face_cull.sv =====
// ----------------------------------------------------------------------------
// omni_shadow_face_cull: six-face cube-map culling of caster boxes, one box
// per cycle while the output register is empty or taken.
// All five stages advance together whenever the output register is empty or taken.
// Reset clears pipeline valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module omni_shadow_face_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   box_valid,
    output logic                                   box_ready,
    input  osfc_pkg::box_t                         box,
    output logic                                   faces_valid,
    input  logic                                   faces_ready,
    output osfc_pkg::face_t                        faces,
    input  logic                                   cfg_wen,
    input  logic [osfc_pkg::CFG_INDEX_BITS-1:0]    cfg_addr,
    input  logic [osfc_pkg::COORD_BITS-1:0]        cfg_wdata
);
    import osfc_pkg::*;

    localparam int WB = wide_bits(FRAC_BITS);

    logic [HALF_BITS-1:0]         near_clip_reg;
    logic [HALF_BITS-1:0]         far_clip_reg;
    logic [SLOPE_BITS-1:0]        slope_reg;
    logic signed [COORD_BITS-1:0] light_x_reg;
    logic signed [COORD_BITS-1:0] light_y_reg;
    logic signed [COORD_BITS-1:0] light_z_reg;

    logic        adv;
    item_flags_t flags_in;
    item_flags_t flags_mid;
    item_flags_t flags_end;
    logic        reject;

    logic signed [WB-1:0] dw [AXES];
    logic signed [WB-1:0] ew [AXES];
    logic signed [WB-1:0] sd [AXES];
    logic signed [WB-1:0] se [AXES];
    logic signed [WB-1:0] bound;
    logic signed [WB-1:0] dw_late [AXES];
    logic signed [WB-1:0] en [AXES];
    logic signed [WB-1:0] fe [AXES];
    logic signed [WB-1:0] tp [AXES][2];
    logic signed [WB-1:0] tm [AXES][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_clip_reg <= NEAR_RESET;
            far_clip_reg  <= FAR_RESET;
            slope_reg     <= SLOPE_RESET;
            light_x_reg   <= LIGHT_RESET;
            light_y_reg   <= LIGHT_RESET;
            light_z_reg   <= LIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_NEAR_CLIP:     near_clip_reg <= cfg_wdata[HALF_BITS-1:0];
                REG_FAR_CLIP:      far_clip_reg  <= cfg_wdata[HALF_BITS-1:0];
                REG_FRUSTUM_SLOPE: slope_reg     <= cfg_wdata[SLOPE_BITS-1:0];
                REG_LIGHT_X:       light_x_reg   <= $signed(cfg_wdata);
                REG_LIGHT_Y:       light_y_reg   <= $signed(cfg_wdata);
                REG_LIGHT_Z:       light_z_reg   <= $signed(cfg_wdata);
                default:           ;
            endcase
        end
    end

    // The whole pipeline moves as one; the output register parts it from
    // the consumer so a new box enters while a result is being taken.
    assign adv       = !faces_valid || faces_ready;
    assign box_ready = adv;

    assign flags_in.valid        = box_valid;
    assign flags_in.eligible     = box.eligible;
    assign flags_in.cull_enabled = box.cull_enabled;

    osfc_offset #(.FRAC_BITS(FRAC_BITS)) u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .flags_in  (flags_in),
        .box       (box),
        .light_x   (light_x_reg),
        .light_y   (light_y_reg),
        .light_z   (light_z_reg),
        .far_clip  (far_clip_reg),
        .slope     (slope_reg),
        .flags_out (flags_mid),
        .dw        (dw),
        .ew        (ew),
        .sd        (sd),
        .se        (se),
        .bound     (bound)
    );

    osfc_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .flags_in  (flags_mid),
        .dw        (dw),
        .ew        (ew),
        .sd        (sd),
        .se        (se),
        .bound     (bound),
        .near_clip (near_clip_reg),
        .far_clip  (far_clip_reg),
        .flags_out (flags_end),
        .reject    (reject),
        .dw_out    (dw_late),
        .en        (en),
        .fe        (fe),
        .tp        (tp),
        .tm        (tm)
    );

    osfc_face #(.FRAC_BITS(FRAC_BITS)) u_face (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .flags_in    (flags_end),
        .reject      (reject),
        .dw          (dw_late),
        .en          (en),
        .fe          (fe),
        .tp          (tp),
        .tm          (tm),
        .faces_valid (faces_valid),
        .faces       (faces)
    );

endmodule

// ===== rtl/osfc_offset.sv =====
// ----------------------------------------------------------------------------
// osfc_offset
// Stages one and two: light-space offset, then slope products and scaling.
// ----------------------------------------------------------------------------
module osfc_offset #(
    parameter int FRAC_BITS = 16,
    localparam int WB = osfc_pkg::wide_bits(FRAC_BITS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  osfc_pkg::item_flags_t                  flags_in,
    input  osfc_pkg::box_t                         box,
    input  logic signed [osfc_pkg::COORD_BITS-1:0] light_x,
    input  logic signed [osfc_pkg::COORD_BITS-1:0] light_y,
    input  logic signed [osfc_pkg::COORD_BITS-1:0] light_z,
    input  logic [osfc_pkg::HALF_BITS-1:0]         far_clip,
    input  logic [osfc_pkg::SLOPE_BITS-1:0]        slope,
    output osfc_pkg::item_flags_t                  flags_out,
    output logic signed [WB-1:0]                   dw [3],
    output logic signed [WB-1:0]                   ew [3],
    output logic signed [WB-1:0]                   sd [3],
    output logic signed [WB-1:0]                   se [3],
    output logic signed [WB-1:0]                   bound
);
    import osfc_pkg::*;

    localparam int DB = COORD_BITS + 1;

    item_flags_t flags1_reg;
    item_flags_t flags2_reg;

    logic signed [DB-1:0]        d_next [AXES];
    logic signed [DB-1:0]        d_reg  [AXES];
    logic [HALF_BITS-1:0]        e_next [AXES];
    logic [HALF_BITS-1:0]        e_reg  [AXES];

    logic signed [DB+SLOPE_BITS:0]       sd_prod [AXES];
    logic [HALF_BITS+SLOPE_BITS-1:0]     se_prod [AXES];
    logic [HALF_BITS+SLOPE_BITS-1:0]     bound_prod;

    logic signed [WB-1:0] dw_next [AXES];
    logic signed [WB-1:0] ew_next [AXES];
    logic signed [WB-1:0] sd_next [AXES];
    logic signed [WB-1:0] se_next [AXES];
    logic signed [WB-1:0] bound_next;

    logic signed [WB-1:0] dw_reg [AXES];
    logic signed [WB-1:0] ew_reg [AXES];
    logic signed [WB-1:0] sd_reg [AXES];
    logic signed [WB-1:0] se_reg [AXES];
    logic signed [WB-1:0] bound_reg;

    always_comb
    begin
        d_next[0] = DB'(box.center_x) - DB'(light_x);
        d_next[1] = DB'(box.center_y) - DB'(light_y);
        d_next[2] = DB'(box.center_z) - DB'(light_z);
        e_next[0] = box.half_x;
        e_next[1] = box.half_y;
        e_next[2] = box.half_z;
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sd_prod[a] = d_reg[a] * $signed({1'b0, slope});
            se_prod[a] = e_reg[a] * slope;
            dw_next[a] = WB'(d_reg[a]) <<< FRAC_BITS;
            ew_next[a] = WB'(e_reg[a]) << FRAC_BITS;
            sd_next[a] = WB'(sd_prod[a]);
            se_next[a] = WB'(se_prod[a]);
        end
        bound_prod = far_clip * slope;
        bound_next = WB'(bound_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags1_reg <= '0;
            flags2_reg <= '0;
        end
        else if (adv)
        begin
            flags1_reg <= flags_in;
            flags2_reg <= flags1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg     <= d_next;
            e_reg     <= e_next;
            dw_reg    <= dw_next;
            ew_reg    <= ew_next;
            sd_reg    <= sd_next;
            se_reg    <= se_next;
            bound_reg <= bound_next;
        end
    end

    assign flags_out = flags2_reg;
    assign dw        = dw_reg;
    assign ew        = ew_reg;
    assign sd        = sd_reg;
    assign se        = se_reg;
    assign bound     = bound_reg;

endmodule

// ===== rtl/osfc_merge.sv =====
// ----------------------------------------------------------------------------
// osfc_merge
// Stages three and four: plane margins, cube bounds and the reject decision.
// ----------------------------------------------------------------------------
module osfc_merge #(
    parameter int FRAC_BITS = 16,
    localparam int WB = osfc_pkg::wide_bits(FRAC_BITS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  osfc_pkg::item_flags_t          flags_in,
    input  logic signed [WB-1:0]           dw [3],
    input  logic signed [WB-1:0]           ew [3],
    input  logic signed [WB-1:0]           sd [3],
    input  logic signed [WB-1:0]           se [3],
    input  logic signed [WB-1:0]           bound,
    input  logic [osfc_pkg::HALF_BITS-1:0] near_clip,
    input  logic [osfc_pkg::HALF_BITS-1:0] far_clip,
    output osfc_pkg::item_flags_t          flags_out,
    output logic                           reject,
    output logic signed [WB-1:0]           dw_out [3],
    output logic signed [WB-1:0]           en [3],
    output logic signed [WB-1:0]           fe [3],
    output logic signed [WB-1:0]           tp [3][2],
    output logic signed [WB-1:0]           tm [3][2]
);
    import osfc_pkg::*;

    localparam logic signed [WB-1:0] ZERO = '0;

    item_flags_t flags3_reg;
    item_flags_t flags4_reg;

    logic signed [WB-1:0] near_w;
    logic signed [WB-1:0] far_w;

    // Stage three.
    logic signed [WB-1:0] p_next   [AXES];
    logic signed [WB-1:0] m_next   [AXES];
    logic signed [WB-1:0] lim_next [AXES];
    logic signed [WB-1:0] en_next  [AXES];
    logic signed [WB-1:0] fe_next  [AXES];
    logic signed [WB-1:0] p_reg    [AXES];
    logic signed [WB-1:0] m_reg    [AXES];
    logic signed [WB-1:0] lim_reg  [AXES];
    logic signed [WB-1:0] en3_reg  [AXES];
    logic signed [WB-1:0] fe3_reg  [AXES];
    logic signed [WB-1:0] dw3_reg  [AXES];
    logic signed [WB-1:0] ew3_reg  [AXES];

    // Stage four.
    logic signed [WB-1:0] tp_next [AXES][2];
    logic signed [WB-1:0] tm_next [AXES][2];
    logic                 reject_next;
    logic signed [WB-1:0] tp_reg  [AXES][2];
    logic signed [WB-1:0] tm_reg  [AXES][2];
    logic                 reject_reg;
    logic signed [WB-1:0] en4_reg [AXES];
    logic signed [WB-1:0] fe4_reg [AXES];
    logic signed [WB-1:0] dw4_reg [AXES];

    assign near_w = WB'(near_clip) << FRAC_BITS;
    assign far_w  = WB'(far_clip) << FRAC_BITS;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            p_next[a]   = se[a] + sd[a];
            m_next[a]   = se[a] - sd[a];
            lim_next[a] = bound + ew[a];
            en_next[a]  = ew[a] - near_w;
            fe_next[a]  = far_w + ew[a];
        end
    end

    // The box leaves the bounding cube when an offset passes the bound on
    // either side along any axis.
    always_comb
    begin
        reject_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                tp_next[a][j] = p_reg[a] + ew3_reg[lateral(a, j)];
                tm_next[a][j] = m_reg[a] + ew3_reg[lateral(a, j)];
            end
            if ((dw3_reg[a] > lim_reg[a]) || ((dw3_reg[a] + lim_reg[a]) < ZERO))
            begin
                reject_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags3_reg <= '0;
            flags4_reg <= '0;
        end
        else if (adv)
        begin
            flags3_reg <= flags_in;
            flags4_reg <= flags3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg      <= p_next;
            m_reg      <= m_next;
            lim_reg    <= lim_next;
            en3_reg    <= en_next;
            fe3_reg    <= fe_next;
            dw3_reg    <= dw;
            ew3_reg    <= ew;
            tp_reg     <= tp_next;
            tm_reg     <= tm_next;
            reject_reg <= reject_next;
            en4_reg    <= en3_reg;
            fe4_reg    <= fe3_reg;
            dw4_reg    <= dw3_reg;
        end
    end

    assign flags_out = flags4_reg;
    assign reject    = reject_reg;
    assign dw_out    = dw4_reg;
    assign en        = en4_reg;
    assign fe        = fe4_reg;
    assign tp        = tp_reg;
    assign tm        = tm_reg;

endmodule

// ===== rtl/osfc_face.sv =====
// ----------------------------------------------------------------------------
// osfc_face
// Stage five: per-face plane tests, mask selection and the output register.
// ----------------------------------------------------------------------------
module osfc_face #(
    parameter int FRAC_BITS = 16,
    localparam int WB = osfc_pkg::wide_bits(FRAC_BITS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  osfc_pkg::item_flags_t flags_in,
    input  logic                  reject,
    input  logic signed [WB-1:0]  dw [3],
    input  logic signed [WB-1:0]  en [3],
    input  logic signed [WB-1:0]  fe [3],
    input  logic signed [WB-1:0]  tp [3][2],
    input  logic signed [WB-1:0]  tm [3][2],
    output logic                  faces_valid,
    output osfc_pkg::face_t       faces
);
    import osfc_pkg::*;

    localparam logic signed [WB-1:0] ZERO = '0;

    logic [FACES-1:0] hit;
    logic [FACES-1:0] mask_next;
    logic             valid_reg;
    face_t            faces_reg;
    face_t            faces_next;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            hit[2*a]   = ((dw[a] + en[a]) > ZERO) && ((fe[a] - dw[a]) > ZERO);
            hit[2*a+1] = ((en[a] - dw[a]) > ZERO) && ((fe[a] + dw[a]) > ZERO);
            for (int j = 0; j < 2; j++)
            begin
                if (!(((tp[a][j] - dw[lateral(a, j)]) > ZERO) &&
                      ((tp[a][j] + dw[lateral(a, j)]) > ZERO)))
                begin
                    hit[2*a] = 1'b0;
                end
                if (!(((tm[a][j] - dw[lateral(a, j)]) > ZERO) &&
                      ((tm[a][j] + dw[lateral(a, j)]) > ZERO)))
                begin
                    hit[2*a+1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (!flags_in.eligible)
        begin
            mask_next = '0;
        end
        else if (!flags_in.cull_enabled)
        begin
            mask_next = ALL_FACES;
        end
        else if (reject)
        begin
            mask_next = '0;
        end
        else
        begin
            mask_next = hit;
        end
        faces_next.face_mask          = mask_next;
        faces_next.visible_this_frame = |mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= flags_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            faces_reg <= faces_next;
        end
    end

    assign faces_valid = valid_reg;
    assign faces       = faces_reg;

endmodule

// ===== rtl/osfc_checker.sv =====
// ----------------------------------------------------------------------------
// osfc_checker
// Port-level checks on the face cull block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osfc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  box_ready,
    input logic                  faces_valid,
    input logic                  faces_ready,
    input osfc_pkg::face_t       faces
);

    logic stalled;
    logic visible_ok;
    logic ready_ok;

    assign stalled    = faces_valid && !faces_ready;
    assign visible_ok = faces.visible_this_frame == (faces.face_mask != '0);
    assign ready_ok   = box_ready == (!faces_valid || faces_ready);

    // A result that is not taken stays on the port unchanged.
    `OSFC_ASSERT_NEXT(a_result_held, stalled, faces_valid && $stable(faces), "result not held")

    // The visible flag agrees with the mask it travels with whenever a result is valid.
    `OSFC_ASSERT_NOW(a_visible_matches, faces_valid, visible_ok, "visible flag wrong")

    // Input backpressure follows the output register alone.
    `OSFC_ASSERT_NOW(a_ready_tracks_output, 1'b1, ready_ok, "ready ignores output stall")

endmodule

bind omni_shadow_face_cull osfc_checker u_osfc_checker (.*);

// ===== tb/omni_shadow_face_cull_tb.sv =====
// ----------------------------------------------------------------------------
// omni_shadow_face_cull_tb
// Streams caster boxes through the cube-map face cull block under random
// idling on both channels. Each accepted box is run through an exact wide
// integer copy of the face tests, and the result is checked field by field.
// Register settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module omni_shadow_face_cull_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import osfc_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int PIPE_LATENCY = 5;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = CFG_INDEX_BITS'(6);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = CFG_INDEX_BITS'(7);

    // Wide enough for every product and sum of the face tests.
    typedef logic signed [79:0] acc_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        box_valid = 1'b0;
    logic                        box_ready;
    box_t                        box = '0;
    logic                        faces_valid;
    logic                        faces_ready = 1'b0;
    face_t                       faces;
    logic                        cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0]   cfg_addr = '0;
    logic [COORD_BITS-1:0]       cfg_wdata = '0;

    // Shadow copy of the light and frustum registers.
    logic [HALF_BITS-1:0]         near_q;
    logic [HALF_BITS-1:0]         far_q;
    logic [SLOPE_BITS-1:0]        slope_q;
    logic signed [COORD_BITS-1:0] light_q [AXES];

    box_t        pending_boxes [$];
    face_t       expected_faces [$];
    logic        box_taken = 1'b0;
    int unsigned idle_pct = 19;
    int          mismatches = 0;
    int          stall_cycles = 0;

    omni_shadow_face_cull #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box),
        .faces_valid(faces_valid),
        .faces_ready(faces_ready),
        .faces      (faces),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic face_t predict_faces(input box_t b);
        logic signed [COORD_BITS-1:0] ctr [AXES];
        logic [HALF_BITS-1:0]         hlf [AXES];
        acc_t                         dw [AXES];
        acc_t                         ew [AXES];
        acc_t                         sd [AXES];
        acc_t                         se [AXES];
        acc_t                         k, lt, near_w, far_w, bound, lim, p, sp, mu, mv;
        logic [FACES-1:0]             mask;
        logic                         reject, ok;
        int                           ax, u, v;
        face_t                        r;
        ctr[0] = b.center_x;
        ctr[1] = b.center_y;
        ctr[2] = b.center_z;
        hlf[0] = b.half_x;
        hlf[1] = b.half_y;
        hlf[2] = b.half_z;
        k = slope_q;
        for (int a = 0; a < AXES; a++)
        begin
            sd[a] = ctr[a];
            lt = light_q[a];
            sd[a] = sd[a] - lt;
            dw[a] = sd[a] <<< FRAC_BITS;
            sd[a] = sd[a] * k;
            se[a] = hlf[a];
            ew[a] = se[a] <<< FRAC_BITS;
            se[a] = se[a] * k;
        end
        near_w = near_q;
        near_w = near_w <<< FRAC_BITS;
        far_w = far_q;
        bound = far_w * k;
        far_w = far_w <<< FRAC_BITS;
        mask = '0;
        if (!b.eligible) begin
            mask = '0;
        end else if (!b.cull_enabled) begin
            mask = ALL_FACES;
        end else begin
            reject = 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                lim = bound + ew[a];
                if (dw[a] > lim || dw[a] < -lim)
                    reject = 1'b1;
            end
            if (!reject) begin
                for (int f = 0; f < FACES; f++)
                begin
                    ax = f / 2;
                    u = (ax + 1) % AXES;
                    v = (ax + 2) % AXES;
                    p = (f % 2 == 1) ? -dw[ax] : dw[ax];
                    sp = (f % 2 == 1) ? -sd[ax] : sd[ax];
                    mu = se[ax] + ew[u];
                    mv = se[ax] + ew[v];
                    ok = (p + ew[ax] > near_w) && (p - ew[ax] < far_w) &&
                         (sp - dw[u] + mu > 0) && (sp + dw[u] + mu > 0) &&
                         (sp - dw[v] + mv > 0) && (sp + dw[v] + mv > 0);
                    mask[f] = ok;
                end
            end
        end
        r.face_mask = mask;
        r.visible_this_frame = |mask;
        return r;
    endfunction

    function automatic box_t make_box(input logic signed [COORD_BITS-1:0] cx,
                                      input logic signed [COORD_BITS-1:0] cy,
                                      input logic signed [COORD_BITS-1:0] cz,
                                      input logic [COORD_BITS-1:0] hx,
                                      input logic [COORD_BITS-1:0] hy,
                                      input logic [COORD_BITS-1:0] hz,
                                      input logic el, input logic cu);
        box_t b;
        b.center_x = cx;
        b.center_y = cy;
        b.center_z = cz;
        b.half_x = hx[HALF_BITS-1:0];
        b.half_y = hy[HALF_BITS-1:0];
        b.half_z = hz[HALF_BITS-1:0];
        b.eligible = el;
        b.cull_enabled = cu;
        return b;
    endfunction

    task automatic queue_box(input box_t b);
        pending_boxes.insert(pending_boxes.size(), b);
    endtask

    function automatic logic [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(3))
            0: return {1'b1, {(COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(COORD_BITS-1){1'b1}}};
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Mostly boxes placed around the light within reach of the frusta, the
    // rest fully random or pinned to the field extremes.
    function automatic box_t random_box();
        box_t                  b;
        longint                reach, off, pos;
        int unsigned           span, mode;
        logic [COORD_BITS-1:0] c [AXES];
        logic [HALF_BITS-1:0]  h [AXES];
        mode = $urandom_range(99);
        reach = (longint'(far_q) * longint'(slope_q)) >>> FRAC_BITS;
        if (reach > (1 << 30))
            reach = 1 << 30;
        case ($urandom_range(3))
            0: span = int'(reach >> 6);
            1: span = int'(reach >> 2);
            2: span = int'(reach);
            default: span = int'(reach + reach / 4);
        endcase
        if (span == 0)
            span = ONE;
        for (int a = 0; a < AXES; a++)
        begin
            if (mode < 10) begin
                c[a] = $urandom;
                h[a] = HALF_BITS'($urandom);
            end else if (mode < 15) begin
                c[a] = extreme_coord();
                h[a] = $urandom_range(1) ? '1 : '0;
            end else begin
                off = $urandom_range(span);
                if ($urandom_range(1))
                    off = -off;
                pos = longint'(light_q[a]) + off;
                c[a] = pos[COORD_BITS-1:0];
                h[a] = ($urandom_range(9) == 0) ? '0 : HALF_BITS'($urandom_range(span >> 3));
            end
        end
        b = make_box(c[0], c[1], c[2], {1'b0, h[0]}, {1'b0, h[1]}, {1'b0, h[2]},
                     1'b1, 1'b1);
        if (mode < 15) begin
            b.eligible = 1'($urandom_range(1));
            b.cull_enabled = 1'($urandom_range(1));
        end else begin
            b.eligible = ($urandom_range(15) != 0);
            b.cull_enabled = ($urandom_range(15) != 0);
        end
        return b;
    endfunction

    // Driver: a box stays on the bus until the block takes it.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            box_valid   <= 1'b0;
            faces_ready <= 1'b0;
        end else begin
            faces_ready <= ($urandom_range(99) >= idle_pct);
            if (!box_valid || box_taken) begin
                if (pending_boxes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    box       <= pending_boxes.pop_front();
                    box_valid <= 1'b1;
                end else begin
                    box_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts on each box transaction, checks each result transaction.
    always @(posedge clk)
    begin
        face_t want;
        if (rst_n) begin
            box_taken = box_valid && box_ready;
            if (box_taken)
                expected_faces.insert(expected_faces.size(), predict_faces(box));
            if (faces_valid && faces_ready) begin
                if (expected_faces.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %b",
                             $time, faces);
                    mismatches++;
                end else begin
                    want = expected_faces.pop_front();
                    if (faces.face_mask !== want.face_mask) begin
                        $display("%0t: face_mask expected %b, actual %b",
                                 $time, want.face_mask, faces.face_mask);
                        mismatches++;
                    end
                    if (faces.visible_this_frame !== want.visible_this_frame) begin
                        $display("%0t: visible_this_frame expected %b, actual %b",
                                 $time, want.visible_this_frame, faces.visible_this_frame);
                        mismatches++;
                    end
                end
            end
            if (box_taken || (faces_valid && faces_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] addr,
                             input logic [COORD_BITS-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (addr)
            REG_NEAR_CLIP:     near_q = value[HALF_BITS-1:0];
            REG_FAR_CLIP:      far_q = value[HALF_BITS-1:0];
            REG_FRUSTUM_SLOPE: slope_q = value[SLOPE_BITS-1:0];
            REG_LIGHT_X:       light_q[0] = value;
            REG_LIGHT_Y:       light_q[1] = value;
            REG_LIGHT_Z:       light_q[2] = value;
            default:           ;
        endcase
    endtask

    task automatic write_settings(input logic [COORD_BITS-1:0] near_v,
                                  input logic [COORD_BITS-1:0] far_v,
                                  input logic [COORD_BITS-1:0] slope_v,
                                  input logic [COORD_BITS-1:0] lx,
                                  input logic [COORD_BITS-1:0] ly,
                                  input logic [COORD_BITS-1:0] lz);
        write_reg(REG_NEAR_CLIP, near_v);
        write_reg(REG_FAR_CLIP, far_v);
        write_reg(REG_FRUSTUM_SLOPE, slope_v);
        write_reg(REG_LIGHT_X, lx);
        write_reg(REG_LIGHT_Y, ly);
        write_reg(REG_LIGHT_Z, lz);
    endtask

    // Holds off new boxes until every outstanding result has come back.
    task automatic drain();
        while (pending_boxes.size() != 0 || box_valid || expected_faces.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic stream_random(input int count);
        for (int i = 0; i < count / 2; i++)
            queue_box(random_box());
        drain();
        for (int i = count / 2; i < count; i++)
            queue_box(random_box());
        drain();
    endtask

    initial
    begin
        near_q = NEAR_RESET;
        far_q = FAR_RESET;
        slope_q = SLOPE_RESET;
        for (int a = 0; a < AXES; a++)
            light_q[a] = LIGHT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed boxes under the reset registers.
        queue_box(make_box(50 * ONE, 0, 0, ONE, ONE, ONE, 1'b0, 1'b1));
        queue_box(make_box(50 * ONE, 0, 0, ONE, ONE, ONE, 1'b0, 1'b0));
        queue_box(make_box(200 * ONE, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        queue_box(make_box(10 * ONE, 0, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(-10 * ONE, ONE, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, 10 * ONE, -ONE, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(ONE, -10 * ONE, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, 0, 10 * ONE, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, 2 * ONE, -10 * ONE, ONE, ONE, ONE, 1'b1, 1'b1));
        // Box around the light reaches all six faces; a point at the light none.
        queue_box(make_box(0, 0, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        // Outside the bounding cube, then exactly on its edge and on the far plane.
        queue_box(make_box(200 * ONE, 0, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, -200 * ONE, 0, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(0, 0, 101 * ONE, ONE, ONE, ONE, 1'b1, 1'b1));
        queue_box(make_box(100 * ONE, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        queue_box(make_box(ONE / 10, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        // Field extremes.
        queue_box(make_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           '1, '1, '1, 1'b1, 1'b1));
        queue_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           '1, '1, '1, 1'b1, 1'b1));
        queue_box(make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                           '0, '1, '0, 1'b1, 1'b1));
        queue_box(make_box(-1, -1, -1, '1, '1, '1, 1'b1, 1'b1));
        queue_box(make_box(-1, -1, -1, '1, '1, '1, 1'b1, 1'b0));
        queue_box(make_box(32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        drain();
        stream_random(160);

        // Bits above the near clip and slope register widths are set and must be dropped.
        write_settings(32'h8001_0000, 50 * ONE, 32'hAB00_8000,
                       10 * ONE, -20 * ONE, 5 * ONE);
        stream_random(180);

        // Widest frusta with the light at the coordinate extremes, no idling.
        idle_pct = 0;
        write_settings(32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        stream_random(180);
        idle_pct = 19;

        // Degenerate frusta: only very large boxes can pass unless culling is off.
        write_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        stream_random(60);

        // Wide field of view with the light placed at random; spare indexes
        // take garbage that must leave every register alone.
        write_settings(ONE / 2, 20 * ONE, 2 * ONE, $urandom, $urandom, $urandom);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        stream_random(180);

        write_settings(COORD_BITS'(NEAR_RESET), COORD_BITS'(FAR_RESET),
                       COORD_BITS'(SLOPE_RESET),
                       LIGHT_RESET, LIGHT_RESET, LIGHT_RESET);
        stream_random(170);

        repeat (PIPE_LATENCY * 4) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
